// ----- sv/dtsp_pkg.sv -----
// Shared types and constants for the device tree structure-block token parser.
// No dependencies; every module refers to it by scoped names.
package dtsp_pkg;

  // Structure-block tokens
  localparam logic [31:0] TOK_BEGIN = 32'h0000_0001;
  localparam logic [31:0] TOK_END   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP  = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP   = 32'h0000_0004;
  localparam logic [31:0] TOK_FIN   = 32'h0000_0009;

  // Event codes reported with every word
  localparam logic [2:0] EV_SKIP  = 3'd0;
  localparam logic [2:0] EV_BEGIN = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_PROP  = 3'd3;
  localparam logic [2:0] EV_NOP   = 3'd4;
  localparam logic [2:0] EV_FIN   = 3'd5;
  localparam logic [2:0] EV_ERR   = 3'd6;

  // Sticky error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_TOKEN = 2'd1;
  localparam logic [1:0] ERR_TOO_DEEP  = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

  // What the parser expects in the next word
  typedef enum logic [2:0] {
    MODE_TOKEN = 3'd0,
    MODE_NAME  = 3'd1,
    MODE_PLEN  = 3'd2,
    MODE_POFF  = 3'd3,
    MODE_DATA  = 3'd4
  } mode_t;

  // Parser state carried from word to word
  typedef struct packed {
    mode_t       mode;
    logic [3:0]  nest_depth;
    logic [30:0] data_words_left;
    logic [31:0] held_length;
    logic [1:0]  sticky_error;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    mode:            MODE_TOKEN,
    nest_depth:      4'd0,
    data_words_left: 31'd0,
    held_length:     32'd0,
    sticky_error:    ERR_NONE
  };

  // One result item
  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  depth;
    logic [31:0] prop_length;
    logic [31:0] str_offset;
    logic [1:0]  error_code;
  } parse_result_t;

endpackage

// ----- sv/dtsp_if.sv -----
// Valid/ready channel interfaces for the structure-block parser.
// Depends on nothing but the widths fixed for the word stream and results.
interface dtsp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        first;

  modport source (output valid, output word, output first, input ready);
  modport sink   (input valid, input word, input first, output ready);
endinterface

interface dtsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [3:0]  depth;
  logic [31:0] prop_length;
  logic [31:0] str_offset;
  logic [1:0]  error_code;

  modport source (output valid, output event_res, output depth, output prop_length,
                  output str_offset, output error_code, input ready);
  modport sink   (input valid, input event_res, input depth, input prop_length,
                  input str_offset, input error_code, output ready);
endinterface

// ----- sv/dtsp_step.sv -----
// Combinational next-state and result logic for one structure-block word.
// Depends on dtsp_pkg for the state, result, token and event definitions.
module dtsp_step #(
  parameter int unsigned MAX_DEPTH = 9
) (
  input  dtsp_pkg::parse_state_t  state,
  input  logic [31:0]             word,
  input  logic                    first,
  output dtsp_pkg::parse_state_t  state_next,
  output dtsp_pkg::parse_result_t result
);

  localparam logic [4:0] DEPTH_LIMIT = 5'(MAX_DEPTH);

  dtsp_pkg::parse_state_t cur;
  logic        zero_byte;
  logic        too_deep;
  logic [32:0] len_round;
  logic [30:0] pad_words;
  logic [30:0] left_dec;
  logic [2:0]  ev;

  // Restart parsing on the first word of a block
  assign cur = first ? dtsp_pkg::STATE_RESET : state;

  assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                     (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
  assign too_deep  = ({1'b0, cur.nest_depth} + 5'd1) > DEPTH_LIMIT;

  // Padded data word count, computed without wrap
  assign len_round = {1'b0, cur.held_length} + 33'd3;
  assign pad_words = len_round[32:2];
  assign left_dec  = cur.data_words_left - 31'(cur.data_words_left != 31'd0);

  // Next state
  always_comb begin
    state_next = cur;
    if (cur.sticky_error == dtsp_pkg::ERR_NONE) begin
      unique case (cur.mode)
        dtsp_pkg::MODE_NAME: begin
          if (zero_byte) state_next.mode = dtsp_pkg::MODE_TOKEN;
        end
        dtsp_pkg::MODE_PLEN: begin
          state_next.held_length = word;
          state_next.mode        = dtsp_pkg::MODE_POFF;
        end
        dtsp_pkg::MODE_POFF: begin
          state_next.data_words_left = pad_words;
          state_next.mode = (pad_words != 31'd0) ? dtsp_pkg::MODE_DATA
                                                 : dtsp_pkg::MODE_TOKEN;
        end
        dtsp_pkg::MODE_DATA: begin
          state_next.data_words_left = left_dec;
          if (left_dec == 31'd0) state_next.mode = dtsp_pkg::MODE_TOKEN;
        end
        default: begin
          state_next.mode = dtsp_pkg::MODE_TOKEN;
          priority if (word == dtsp_pkg::TOK_BEGIN) begin
            if (too_deep) begin
              state_next.sticky_error = dtsp_pkg::ERR_TOO_DEEP;
            end else begin
              state_next.nest_depth = cur.nest_depth + 4'd1;
              state_next.mode       = dtsp_pkg::MODE_NAME;
            end
          end else if (word == dtsp_pkg::TOK_END) begin
            if (cur.nest_depth == 4'd0) begin
              state_next.sticky_error = dtsp_pkg::ERR_UNDERFLOW;
            end else begin
              state_next.nest_depth = cur.nest_depth - 4'd1;
            end
          end else if (word == dtsp_pkg::TOK_PROP) begin
            state_next.mode = dtsp_pkg::MODE_PLEN;
          end else if (word == dtsp_pkg::TOK_NOP || word == dtsp_pkg::TOK_FIN) begin
            state_next.mode = dtsp_pkg::MODE_TOKEN;
          end else begin
            state_next.sticky_error = dtsp_pkg::ERR_BAD_TOKEN;
          end
        end
      endcase
    end
  end

  // Event for this word
  always_comb begin
    ev = dtsp_pkg::EV_SKIP;
    if (cur.sticky_error != dtsp_pkg::ERR_NONE) begin
      ev = dtsp_pkg::EV_ERR;
    end else begin
      unique case (cur.mode)
        dtsp_pkg::MODE_NAME, dtsp_pkg::MODE_PLEN, dtsp_pkg::MODE_DATA: begin
          ev = dtsp_pkg::EV_SKIP;
        end
        dtsp_pkg::MODE_POFF: begin
          ev = dtsp_pkg::EV_PROP;
        end
        default: begin
          priority if (word == dtsp_pkg::TOK_BEGIN) begin
            ev = too_deep ? dtsp_pkg::EV_ERR : dtsp_pkg::EV_BEGIN;
          end else if (word == dtsp_pkg::TOK_END) begin
            ev = (cur.nest_depth == 4'd0) ? dtsp_pkg::EV_ERR : dtsp_pkg::EV_END;
          end else if (word == dtsp_pkg::TOK_PROP) begin
            ev = dtsp_pkg::EV_SKIP;
          end else if (word == dtsp_pkg::TOK_NOP) begin
            ev = dtsp_pkg::EV_NOP;
          end else if (word == dtsp_pkg::TOK_FIN) begin
            ev = dtsp_pkg::EV_FIN;
          end else begin
            ev = dtsp_pkg::EV_ERR;
          end
        end
      endcase
    end
  end

  // Assemble the result item
  always_comb begin
    result.event_res   = ev;
    result.depth       = state_next.nest_depth;
    result.prop_length = (ev == dtsp_pkg::EV_PROP) ? cur.held_length : 32'd0;
    result.str_offset  = (ev == dtsp_pkg::EV_PROP) ? word : 32'd0;
    result.error_code  = (ev == dtsp_pkg::EV_ERR) ? state_next.sticky_error
                                                  : dtsp_pkg::ERR_NONE;
  end

endmodule

// ----- sv/device_tree_struct_token_parser_top.sv -----
// Top level of the device tree structure-block token parser.
// Depends on dtsp_pkg, the dtsp_in_if / dtsp_out_if interfaces and dtsp_step.
//
//   Channel   Direction  Payload                                         Per request
//   in_ch     in         word[31:0], first                               one block word
//   out_ch    out        event_res, depth, prop_length, str_offset,      one result
//                        error_code
//
// One word per cycle unless the output stalls: each request passes through dtsp_step
// and lands in the result register when accepted; its result is offered next cycle.
// The parser state register updates on every accepted request; rst (synchronous)
// returns it to "expecting a token" at depth zero with no error and empties the
// result register. A stalled output blocks input only while the result register
// is full and not being taken this cycle.
module device_tree_struct_token_parser_top #(
  parameter int unsigned MAX_DEPTH = 9
) (
  input  logic              clk,
  input  logic              rst,
  dtsp_in_if.sink           in_ch,
  dtsp_out_if.source        out_ch
);

  dtsp_pkg::parse_state_t  state;
  dtsp_pkg::parse_state_t  state_next;
  dtsp_pkg::parse_result_t step_res;
  dtsp_pkg::parse_result_t res;
  logic                    res_valid;
  logic                    accept;

  dtsp_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .state      (state),
    .word       (in_ch.word),
    .first      (in_ch.first),
    .state_next (state_next),
    .result     (step_res)
  );

  // Take a request whenever the result register is free or draining
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Advance parser state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtsp_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.event_res   = res.event_res;
  assign out_ch.depth       = res.depth;
  assign out_ch.prop_length = res.prop_length;
  assign out_ch.str_offset  = res.str_offset;
  assign out_ch.error_code  = res.error_code;

endmodule
